[hdl/tgcc_pkg.sv]
// Package for the tile grid connectivity check.
// Holds tile port decode, field widths, control types and FSM codes.
// No dependencies.
package tgcc_pkg;

	localparam int DEF_GRID_ROWS = 8;
	localparam int DEF_GRID_COLS = 8;

	localparam int TILE_W   = 4;
	localparam int START_W  = 7;
	localparam int REACH_W  = 7;
	localparam int LAST_CODE = 10;
	localparam int REACH_MAX = 127;

	localparam logic [START_W-1:0] START_RESET = 7'd64;

	// Port mask bit positions
	localparam int P_L = 0;
	localparam int P_R = 1;
	localparam int P_U = 2;
	localparam int P_D = 3;

	typedef logic [3:0] port_mask_t;

	// Per-cycle commands from the sequencer to every cell
	typedef struct packed {
		logic load;
		logic seed;
		logic fill;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEED   = 5'b00010,
		ST_FILL   = 5'b00100,
		ST_COUNT  = 5'b01000,
		ST_REPORT = 5'b10000
	} state_t;

	// Decode a tile code into its open ports; codes past LAST_CODE open none
	function automatic port_mask_t code_ports(input logic [TILE_W-1:0] code);
		port_mask_t m;
		m = '0;
		unique case (code)
			4'd0:    m = (4'b1 << P_R) | (4'b1 << P_L);
			4'd1:    m = (4'b1 << P_U) | (4'b1 << P_D);
			4'd2:    m = (4'b1 << P_L) | (4'b1 << P_D);
			4'd3:    m = (4'b1 << P_L) | (4'b1 << P_U);
			4'd4:    m = (4'b1 << P_R) | (4'b1 << P_U);
			4'd5:    m = (4'b1 << P_R) | (4'b1 << P_D);
			4'd6:    m = (4'b1 << P_L) | (4'b1 << P_U) | (4'b1 << P_D);
			4'd7:    m = (4'b1 << P_R) | (4'b1 << P_L) | (4'b1 << P_U);
			4'd8:    m = (4'b1 << P_R) | (4'b1 << P_U) | (4'b1 << P_D);
			4'd9:    m = (4'b1 << P_R) | (4'b1 << P_L) | (4'b1 << P_D);
			4'd10:   m = 4'b1111;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

[hdl/tgcc_cell.sv]
// One grid cell: holds its port mask and visited bit.
// Spreads the visited mark from linked neighbors and shifts it out for counting.
// Depends on tgcc_pkg.
module tgcc_cell #(
	parameter int IDX   = 0,
	parameter int POS_W = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgcc_pkg::cell_ctrl_t          ctrl,
	input  logic [POS_W-1:0]              load_pos,
	input  tgcc_pkg::port_mask_t          tile_mask,
	input  logic [tgcc_pkg::START_W-1:0]  start_node,
	input  logic [3:0]                    nb_vis,
	input  logic [3:0]                    nb_open,
	input  logic                          shift_in,
	output tgcc_pkg::port_mask_t          mask_q,
	output logic                          vis_q
);
	import tgcc_pkg::*;

	logic load_hit;
	logic seed_hit;
	logic linked;

	assign load_hit = ctrl.load && (load_pos == POS_W'(IDX));
	assign seed_hit = (int'(start_node) == IDX);
	assign linked   = |(nb_vis & nb_open & mask_q);

	// Store the tile mask when this cell is addressed
	always_ff @(posedge clk) begin
		if (load_hit) begin
			mask_q <= tile_mask;
		end
	end

	// Seed, spread, or shift the visited mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q <= 1'b0;
		end else if (ctrl.seed) begin
			vis_q <= seed_hit;
		end else if (ctrl.fill) begin
			vis_q <= vis_q | linked;
		end else if (ctrl.shift) begin
			vis_q <= shift_in;
		end
	end

endmodule

[hdl/tgcc_ctrl.sv]
// Sequencer: tile load position, flood fill and count phases, result registers.
// Drives the command struct shared by all cells.
// Depends on tgcc_pkg.
module tgcc_ctrl #(
	parameter int NUM_CELLS = 64,
	parameter int POS_W     = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          last_tile,
	input  logic [tgcc_pkg::START_W-1:0]  start_node,
	input  logic                          tail_vis,
	input  logic                          tail_right,
	output logic                          busy,
	output tgcc_pkg::cell_ctrl_t          ctrl,
	output logic [POS_W-1:0]              load_pos,
	output logic                          done,
	output logic                          all_reached,
	output logic [tgcc_pkg::REACH_W-1:0]  reached_cells,
	output logic                          exit_reached
);
	import tgcc_pkg::*;

	localparam int CNT_W = $clog2(NUM_CELLS + 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_CELLS - 1);

	state_t           st_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] cyc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             exit_q;
	logic             done_q;
	logic             accept;
	logic             entr;
	logic             exit_seed;

	assign accept    = start && (st_q == ST_IDLE);
	assign entr      = (int'(start_node) == NUM_CELLS);
	assign exit_seed = (int'(start_node) == NUM_CELLS + 1);

	assign busy       = (st_q != ST_IDLE);
	assign load_pos   = pos_q;
	assign ctrl.load  = accept;
	assign ctrl.seed  = (st_q == ST_SEED);
	assign ctrl.fill  = (st_q == ST_FILL);
	assign ctrl.shift = (st_q == ST_COUNT);
	assign done       = done_q;

	// Advance the phase sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			pos_q  <= '0;
			cyc_q  <= '0;
			cnt_q  <= '0;
			exit_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_tile) begin
							pos_q <= '0;
							st_q  <= ST_SEED;
						end else if (pos_q == POS_LAST) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_SEED: begin
					cyc_q <= '0;
					cnt_q <= '0;
					st_q  <= ST_FILL;
				end
				ST_FILL: begin
					if (cyc_q == POS_LAST) begin
						cyc_q <= '0;
						st_q  <= ST_COUNT;
					end else begin
						cyc_q <= cyc_q + 1'b1;
					end
				end
				ST_COUNT: begin
					// Tail cell still holds its settled mark on the first count cycle
					if (cyc_q == '0) begin
						exit_q <= (tail_vis && tail_right) || exit_seed;
					end
					cnt_q <= cnt_q + CNT_W'(tail_vis);
					if (cyc_q == POS_LAST) begin
						st_q <= ST_REPORT;
					end else begin
						cyc_q <= cyc_q + 1'b1;
					end
				end
				ST_REPORT: begin
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result fields for the strobe cycle
	always_ff @(posedge clk) begin
		if (st_q == ST_REPORT) begin
			all_reached   <= entr && exit_q && (int'(cnt_q) == NUM_CELLS);
			exit_reached  <= exit_q;
			reached_cells <= (int'(cnt_q) > REACH_MAX) ? REACH_W'(REACH_MAX)
			                                          : REACH_W'(cnt_q);
		end
	end

endmodule

[hdl/tile_grid_connectivity_check_top.sv]
// Top level of the tile grid connectivity check.
// Instantiates the grid of cells and the sequencer; holds the start node register.
// Depends on tgcc_pkg, tgcc_cell, tgcc_ctrl.
//
// channel   ports                                       handshake
// tile in   tile_code, last_tile                        start & !busy
// result    all_reached, reached_cells, exit_reached    done, one cycle, no stall
// config    start_node                                  start_node_we
//
// A tile without the last mark is stored in the cell at the load position. The last tile
// is followed by the seed state, the fill phase (one hop of the visited mark per cycle along
// the cell links), the count phase that shifts the marks out to the counter, and the report
// state; busy is high from the seed state through the report state. done pulses in the
// cycle after the report state; busy is low again in the same cycle. Reset clears visited
// marks, load position and sequencer; start_node resets to the entrance node.
module tile_grid_connectivity_check_top #(
	parameter int GRID_ROWS = tgcc_pkg::DEF_GRID_ROWS,
	parameter int GRID_COLS = tgcc_pkg::DEF_GRID_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tgcc_pkg::TILE_W-1:0]   tile_code,
	input  logic                          last_tile,
	input  logic                          start_node_we,
	input  logic [tgcc_pkg::START_W-1:0]  start_node,
	output logic                          done,
	output logic                          all_reached,
	output logic [tgcc_pkg::REACH_W-1:0]  reached_cells,
	output logic                          exit_reached
);
	import tgcc_pkg::*;

	localparam int NUM_CELLS = GRID_ROWS * GRID_COLS;
	localparam int POS_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	logic [START_W-1:0] start_node_q;
	cell_ctrl_t         ctrl;
	logic [POS_W-1:0]   load_pos;
	port_mask_t         tile_mask;
	port_mask_t         mask [NUM_CELLS];
	logic [NUM_CELLS-1:0] vis;
	logic               entr;

	assign tile_mask = code_ports(tile_code);
	assign entr      = (int'(start_node_q) == NUM_CELLS);

	// Hold the start node register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_node_q <= START_RESET;
		end else if (start_node_we) begin
			start_node_q <= start_node;
		end
	end

	// Grid of cells with neighbor links
	for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
		for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
			localparam int I = r * GRID_COLS + c;
			logic [3:0] nb_vis;
			logic [3:0] nb_open;
			logic       shift_in;

			if (c == 0) begin : g_l_edge
				if (I == 0) begin : g_entr
					assign nb_vis[P_L]  = entr;
					assign nb_open[P_L] = 1'b1;
				end else begin : g_none
					assign nb_vis[P_L]  = 1'b0;
					assign nb_open[P_L] = 1'b0;
				end
			end else begin : g_l
				assign nb_vis[P_L]  = vis[I-1];
				assign nb_open[P_L] = mask[I-1][P_R];
			end

			if (c == GRID_COLS - 1) begin : g_r_edge
				assign nb_vis[P_R]  = 1'b0;
				assign nb_open[P_R] = 1'b0;
			end else begin : g_r
				assign nb_vis[P_R]  = vis[I+1];
				assign nb_open[P_R] = mask[I+1][P_L];
			end

			if (r == 0) begin : g_u_edge
				assign nb_vis[P_U]  = 1'b0;
				assign nb_open[P_U] = 1'b0;
			end else begin : g_u
				assign nb_vis[P_U]  = vis[I-GRID_COLS];
				assign nb_open[P_U] = mask[I-GRID_COLS][P_D];
			end

			if (r == GRID_ROWS - 1) begin : g_d_edge
				assign nb_vis[P_D]  = 1'b0;
				assign nb_open[P_D] = 1'b0;
			end else begin : g_d
				assign nb_vis[P_D]  = vis[I+GRID_COLS];
				assign nb_open[P_D] = mask[I+GRID_COLS][P_U];
			end

			if (I == 0) begin : g_shift_head
				assign shift_in = 1'b0;
			end else begin : g_shift
				assign shift_in = vis[I-1];
			end

			tgcc_cell #(
				.IDX   (I),
				.POS_W (POS_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.load_pos   (load_pos),
				.tile_mask  (tile_mask),
				.start_node (start_node_q),
				.nb_vis     (nb_vis),
				.nb_open    (nb_open),
				.shift_in   (shift_in),
				.mask_q     (mask[I]),
				.vis_q      (vis[I])
			);
		end
	end

	tgcc_ctrl #(
		.NUM_CELLS (NUM_CELLS),
		.POS_W     (POS_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_tile     (last_tile),
		.start_node    (start_node_q),
		.tail_vis      (vis[NUM_CELLS-1]),
		.tail_right    (mask[NUM_CELLS-1][P_R]),
		.busy          (busy),
		.ctrl          (ctrl),
		.load_pos      (load_pos),
		.done          (done),
		.all_reached   (all_reached),
		.reached_cells (reached_cells),
		.exit_reached  (exit_reached)
	);

endmodule
